>>> rtl/core/ic3_pkg.sv
`default_nettype none

package ic3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int KERNEL_SIZE = 3;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 8;
  localparam int PIX_W       = 8;
  localparam int SIZE_W      = 11;

  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W0  = $clog2(DIM_MAX + 2);
  localparam int DIM_W   = (DIM_W0 > SIZE_W) ? DIM_W0 : SIZE_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);

  localparam int COEF_ROW_W  = KERNEL_SIZE * COEF_BITS;
  localparam int CFG_DATA_W  = COEF_ROW_W;
  localparam int CFG_INDEX_W = 3;

  localparam int PROD_W = PIX_W + 1 + COEF_BITS;
  localparam int PART_W = PROD_W + $clog2(KERNEL_SIZE);
  localparam int SUM_W  = PART_W + $clog2(KERNEL_SIZE);

  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOTTOM
  } cfg_reg_t;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } res_t;

  typedef logic [KERNEL_SIZE-1:0][COEF_BITS-1:0] kernel_vec_t;
  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0]     col_pix_t;

  typedef struct packed {
    logic                   shift;
    logic [KERNEL_SIZE-1:0] row_en;
    logic                   col_en;
  } cell_ctl_t;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam kernel_vec_t COEF_TOP_RST    = 48'h0000_0000_0000;
  localparam kernel_vec_t COEF_MID_RST    = 48'h0000_0100_0000;
  localparam kernel_vec_t COEF_BOTTOM_RST = 48'h0000_0000_0000;

endpackage

`default_nettype wire

>>> rtl/core/ic3_ram.sv
`default_nettype none

module ic3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ic3_cell.sv
`default_nettype none

module ic3_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  ic3_pkg::cell_ctl_t                 ctl,
  input  ic3_pkg::col_pix_t                  pix_in,
  input  ic3_pkg::kernel_vec_t               coef,
  output ic3_pkg::col_pix_t                  pix,
  output logic signed [ic3_pkg::PART_W-1:0]  partial
);
  import ic3_pkg::*;

  logic signed [PROD_W-1:0] prod      [KERNEL_SIZE];
  logic signed [PROD_W-1:0] prod_next [KERNEL_SIZE];
  logic signed [PART_W-1:0] partial_next;

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      if (ctl.row_en[r] && ctl.col_en) begin
        prod_next[r] = PROD_W'($signed({1'b0, pix[r]})) * PROD_W'($signed(coef[r]));
      end else begin
        prod_next[r] = '0;
      end
    end
  end

  always_comb begin
    partial_next = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      partial_next = partial_next + PART_W'(prod[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (ctl.shift) begin
      pix <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= prod_next;
    partial <= partial_next;
  end

endmodule

`default_nettype wire

>>> rtl/core/ic3_outq.sv
`default_nettype none

module ic3_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  ic3_pkg::res_t                 wr_data,
  input  logic                          rd_ready,
  output logic                          rd_valid,
  output ic3_pkg::res_t                 rd_data,
  output logic [ic3_pkg::OQ_CNT_W-1:0]  level
);
  import ic3_pkg::*;

  res_t                slots [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] level_next;
  logic                rd;

  assign rd_valid = (level != '0);
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = slots[rd_ptr];

  always_comb begin
    case ({wr, rd})
      2'b10:   level_next = level + OQ_CNT_W'(1);
      2'b01:   level_next = level - OQ_CNT_W'(1);
      default: level_next = level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (level != OQ_CNT_W'(OQ_DEPTH)))
    else $error("result queue written while full");
`endif

endmodule

`default_nettype wire

>>> rtl/core/image_convolution_3x3.sv
`default_nettype none

// channel  | signals                        | transfer when
// ---------+--------------------------------+-----------------------------------
// request  | req_valid, req_ready, req      | req_valid && req_ready
// result   | rsp_valid, rsp_ready, rsp      | rsp_valid && rsp_ready
// config   | cfg_write, cfg_index, cfg_data | cfg_write
//
// One request per cycle while req_ready is high. A result passes these steps between its request
// transfer and the queue: line store read, window shift, products, column
// sums, final sum and clamp.
// Reset clears counters and window and loads config defaults; line stores are not cleared.
// A stalled result side fills an 8-entry queue; req_ready drops only when
// queued plus in-flight results reach its depth.

module image_convolution_3x3 (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ic3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  ic3_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output ic3_pkg::res_t                    rsp
);
  import ic3_pkg::*;

  localparam int PIPE_SLOTS = 4;
  localparam int INFL_W     = $clog2(PIPE_SLOTS + 1);
  localparam int CREDIT_W   = OQ_CNT_W + 1;

  typedef struct packed {
    logic [COL_W-1:0]       col;
    logic [PIX_W-1:0]       newpix;
    logic                   res;
    logic                   last;
    logic [KERNEL_SIZE-1:0] row_en;
    logic [KERNEL_SIZE-1:0] col_en;
    logic                   fwd;
    logic [PIX_W-1:0]       fwd_a;
    logic [PIX_W-1:0]       fwd_b;
  } item_t;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  kernel_vec_t       coef_rows [KERNEL_SIZE];

  logic [COL_W-1:0] in_column, in_column_next;
  logic [DIM_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_col, out_col_next;
  logic [DIM_W-1:0] out_row, out_row_next;

  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] out_col_inc;
  logic [DIM_W-1:0] out_row_inc;
  logic             draining;
  logic             ignore;
  logic             take;
  logic             accept_item;
  logic [PIX_W-1:0] newpix;
  logic             has_res;
  logic             last;
  logic             top_edge;
  logic             bottom_edge;
  logic             left_edge;
  logic             right_edge;

  logic                   s1_valid;
  item_t                  s1, s1_next;
  logic                   s2_valid;
  logic [KERNEL_SIZE-1:0] s2_row_en;
  logic [KERNEL_SIZE-1:0] s2_col_en;
  logic                   s2_last;
  logic                   s3_valid;
  logic                   s3_last;
  logic                   s4_valid;
  logic                   s4_last;

  logic [PIX_W-1:0] line_a_rd;
  logic [PIX_W-1:0] line_b_rd;
  logic [PIX_W-1:0] mid_s1;
  logic [PIX_W-1:0] top_s1;

  col_pix_t                 col_pix  [KERNEL_SIZE+1];
  kernel_vec_t              coef_col [KERNEL_SIZE];
  cell_ctl_t                cell_ctl [KERNEL_SIZE];
  logic signed [PART_W-1:0] partial  [KERNEL_SIZE];
  logic signed [SUM_W-1:0]  acc;
  logic [PIX_W-1:0]         pix_res;
  res_t                     oq_data;

  logic [OQ_CNT_W-1:0] oq_level;
  logic [INFL_W-1:0]   inflight;

  // frame size, zero acts as one and oversize as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(frame_width) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(frame_height) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(frame_height);
    end
  end

  assign inflight = INFL_W'(s1_valid && s1.res) + INFL_W'(s2_valid)
                  + INFL_W'(s3_valid) + INFL_W'(s4_valid);
  assign req_ready = (CREDIT_W'(oq_level) + CREDIT_W'(inflight)) < CREDIT_W'(OQ_DEPTH);

  assign draining    = in_row >= h_eff;
  assign ignore      = req.req_type && !draining;
  assign take        = req_valid && req_ready;
  assign accept_item = take && !ignore;
  assign newpix      = draining ? '0 : req.pixel_in;

  assign col_inc     = DIM_W'(in_column) + DIM_W'(1);
  assign out_col_inc = DIM_W'(out_col) + DIM_W'(1);
  assign out_row_inc = out_row + DIM_W'(1);

  always_comb begin
    if (in_row == '0) begin
      has_res = DIM_W'(in_column) > w_eff;
    end else if (in_row == DIM_W'(1)) begin
      has_res = in_column != '0;
    end else begin
      has_res = 1'b1;
    end
  end

  assign top_edge    = out_row == '0;
  assign bottom_edge = out_row_inc >= h_eff;
  assign left_edge   = out_col == '0;
  assign right_edge  = out_col_inc >= w_eff;
  assign last        = bottom_edge && right_edge;

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (accept_item) begin
      if (col_inc >= w_eff) begin
        in_column_next = '0;
        in_row_next    = in_row + DIM_W'(1);
      end else begin
        in_column_next = COL_W'(col_inc);
      end
      if (has_res) begin
        if (last) begin
          in_column_next = '0;
          in_row_next    = '0;
          out_col_next   = '0;
          out_row_next   = '0;
        end else if (right_edge) begin
          out_col_next = '0;
          out_row_next = out_row_inc;
        end else begin
          out_col_next = COL_W'(out_col_inc);
        end
      end
    end
  end

  // the line store written in stage 1 is read in the same cycle: bypass it
  assign mid_s1 = s1.fwd ? s1.fwd_a : line_a_rd;
  assign top_s1 = s1.fwd ? s1.fwd_b : line_b_rd;

  always_comb begin
    s1_next.col    = in_column;
    s1_next.newpix = newpix;
    s1_next.res    = has_res;
    s1_next.last   = last;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      s1_next.row_en[i] = !((i == 0 && top_edge) || (i == KERNEL_SIZE - 1 && bottom_edge));
      s1_next.col_en[i] = !((i == 0 && left_edge) || (i == KERNEL_SIZE - 1 && right_edge));
    end
    s1_next.fwd   = s1_valid && (s1.col == in_column);
    s1_next.fwd_a = s1.newpix;
    s1_next.fwd_b = mid_s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      coef_rows[0] <= COEF_TOP_RST;
      coef_rows[1] <= COEF_MID_RST;
      coef_rows[2] <= COEF_BOTTOM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
        REG_COEF_TOP:     coef_rows[0] <= cfg_data;
        REG_COEF_MID:     coef_rows[1] <= cfg_data;
        REG_COEF_BOTTOM:  coef_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_col   <= '0;
      out_row   <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
      s1_valid  <= accept_item;
      s2_valid  <= s1_valid && s1.res;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1        <= s1_next;
    s2_row_en <= s1.row_en;
    s2_col_en <= s1.col_en;
    s2_last   <= s1.last;
    s3_last   <= s2_last;
    s4_last   <= s3_last;
  end

  ic3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (s1.newpix),
    .re    (accept_item),
    .raddr (in_column),
    .rdata (line_a_rd)
  );

  ic3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.col),
    .wdata (mid_s1),
    .re    (accept_item),
    .raddr (in_column),
    .rdata (line_b_rd)
  );

  assign col_pix[KERNEL_SIZE] = {s1.newpix, mid_s1, top_s1};

  always_comb begin
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
        coef_col[j][r] = coef_rows[r][j];
      end
      cell_ctl[j].shift  = s1_valid;
      cell_ctl[j].row_en = s2_row_en;
      cell_ctl[j].col_en = s2_col_en[j];
    end
  end

  for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
    ic3_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl[j]),
      .pix_in  (col_pix[j+1]),
      .coef    (coef_col[j]),
      .pix     (col_pix[j]),
      .partial (partial[j])
    );
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      acc = acc + SUM_W'(partial[j]);
    end
  end

  // clamp negative to zero, drop fraction, saturate
  always_comb begin
    if (acc[SUM_W-1]) begin
      pix_res = '0;
    end else if (|acc[SUM_W-2:COEF_FRAC+PIX_W]) begin
      pix_res = '1;
    end else begin
      pix_res = acc[COEF_FRAC+PIX_W-1:COEF_FRAC];
    end
    oq_data.pixel_out  = pix_res;
    oq_data.frame_last = s4_last;
  end

  ic3_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr       (s4_valid),
    .wr_data  (oq_data),
    .rd_ready (rsp_ready),
    .rd_valid (rsp_valid),
    .rd_data  (rsp),
    .level    (oq_level)
  );

`ifndef SYNTH
  a_credit: assert property (@(posedge clk) disable iff (rst)
    (CREDIT_W'(oq_level) + CREDIT_W'(inflight)) <= CREDIT_W'(OQ_DEPTH))
    else $error("queued plus in-flight results exceed queue depth");

  a_ignored_tick: assert property (@(posedge clk) disable iff (rst)
    (take && ignore) |=> ($stable(in_column) && $stable(in_row)
                          && $stable(out_col) && $stable(out_row)))
    else $error("early drain transfer moved the position counters");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept_item && has_res && last) |=> (in_column == '0 && in_row == '0
                                          && out_col == '0 && out_row == '0))
    else $error("counters not cleared after last result of frame");
`endif

endmodule

`default_nettype wire

>>> tb/image_convolution_3x3_checker.sv
`timescale 1ns / 100ps

module image_convolution_3x3_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ic3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ic3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  ic3_pkg::req_t                   req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  ic3_pkg::res_t                   rsp,
  output int                              errors,
  output int                              pending,
  output int                              results_seen,
  output int                              frames_seen
);
  import ic3_pkg::*;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  kernel_vec_t       kernel [KERNEL_SIZE];

  logic [PIX_W-1:0] row_above  [MAX_WIDTH];
  logic [PIX_W-1:0] row_above2 [MAX_WIDTH];
  logic [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE];
  int               col_in, row_in, col_out, row_out;

  res_t pixels_due[$];

  function automatic int fit_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit convolve_step(req_t r, output res_t o);
    int               w, h, col, sum, scaled;
    logic [PIX_W-1:0] npix, top, mid;
    bit               draining, last;
    w = fit_size(width_reg, MAX_WIDTH);
    h = fit_size(height_reg, MAX_HEIGHT);
    draining = row_in >= h;
    o = '0;
    sum = 0;
    if (r.req_type && !draining) return 0;
    npix = draining ? '0 : r.pixel_in;

    col = (col_in >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_in;
    top = row_above2[col];
    mid = row_above[col];
    row_above2[col] = mid;
    row_above[col] = npix;

    for (int k = 0; k < KERNEL_SIZE; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = npix;

    if (row_in * w + col_in < w + 1) begin
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      return 0;
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end

    // drop neighbours that fall outside the frame
    for (int k = 0; k < KERNEL_SIZE; k++)
      for (int c = 0; c < KERNEL_SIZE; c++)
        if (!(k == 0 && row_out == 0) && !(k == 2 && row_out + 1 >= h) &&
            !(c == 0 && col_out == 0) && !(c == 2 && col_out + 1 >= w))
          sum += int'(win[k][c]) * int'($signed(kernel[k][c]));

    scaled = sum >>> COEF_FRAC;
    if (sum < 0) o.pixel_out = '0;
    else if (scaled > 255) o.pixel_out = '1;
    else o.pixel_out = PIX_W'(scaled);

    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    o.frame_last = last;
    if (last) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1;
  endfunction

  task automatic report_miss(string what, res_t want);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected pixel %0d last %0d, got pixel %0d last %0d", $time, what,
               want.pixel_out, want.frame_last, rsp.pixel_out, rsp.frame_last);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      kernel[0] = COEF_TOP_RST;
      kernel[1] = COEF_MID_RST;
      kernel[2] = COEF_BOTTOM_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_above2[i] = '0;
      end
      for (int k = 0; k < KERNEL_SIZE; k++)
        for (int c = 0; c < KERNEL_SIZE; c++)
          win[k][c] = '0;
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
      pixels_due.delete();
      errors = 0;
      results_seen = 0;
      frames_seen = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        results_seen++;
        if (pixels_due.size() == 0) begin
          report_miss("unexpected result", '0);
        end else begin
          want = pixels_due.pop_front();
          if (rsp.pixel_out !== want.pixel_out || rsp.frame_last !== want.frame_last)
            report_miss("result mismatch", want);
        end
        if (rsp.frame_last === 1'b1) frames_seen++;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg = cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data[SIZE_W-1:0];
          REG_COEF_TOP:     kernel[0] = cfg_data;
          REG_COEF_MID:     kernel[1] = cfg_data;
          REG_COEF_BOTTOM:  kernel[2] = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        if (convolve_step(req, want)) pixels_due.push_back(want);
      end
    end
    pending = pixels_due.size();
  end

endmodule

>>> tb/tb_image_convolution_3x3.sv
`timescale 1ns / 100ps

module tb_image_convolution_3x3;
  import ic3_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  res_t                   rsp;

  int errors, pending, results_seen, frames_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  int frame_w, frame_h;

  always #4 clk = ~clk;

  image_convolution_3x3 i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  image_convolution_3x3_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .frames_seen  (frames_seen)
  );

  always @(negedge clk) begin
    rsp_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_image_convolution_3x3 failed");
      $finish;
    end
  end

  task automatic push_req(bit drain, logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= {drain, pix};
    do @(posedge clk); while (!req_ready);
    items_sent++;
  endtask

  task automatic hold_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic load_setup(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                            kernel_vec_t top, kernel_vec_t mid, kernel_vec_t bot);
    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    put_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    put_reg(REG_COEF_TOP, top);
    put_reg(REG_COEF_MID, mid);
    put_reg(REG_COEF_BOTTOM, bot);
    cfg_write <= 1'b0;
    frame_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
    frame_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h);
    settings_used++;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 83;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 83;
      end
      default: begin
        send_idle_pct = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic kernel_vec_t pick_kernel_row(int style);
    kernel_vec_t k;
    for (int c = 0; c < KERNEL_SIZE; c++) begin
      case (style)
        0: k[c] = COEF_BITS'($urandom);
        2: begin
          case ($urandom_range(3))
            0: k[c] = 16'h8000;
            1: k[c] = 16'h7FFF;
            2: k[c] = 16'hFFFF;
            default: k[c] = 16'h0100;
          endcase
        end
        default: k[c] = COEF_BITS'($urandom_range(160) - 80);
      endcase
    end
    return k;
  endfunction

  // frame pixels with stray drain ticks, then the flush; the flush mixes
  // drain ticks with pixels that arrive after the frame is complete
  task automatic run_frame(bit hold_mid);
    int n;
    n = frame_w * frame_h;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) hold_for_results();
      if ($urandom_range(39) == 0) push_req(1'b1, PIX_W'($urandom));
      push_req(1'b0, pick_pixel());
    end
    for (int i = 0; i <= frame_w; i++) push_req($urandom_range(3) != 0, PIX_W'($urandom));
    if ($urandom_range(3) == 0) push_req(1'b1, PIX_W'($urandom));
  endtask

  task automatic run_setting(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, int nframes);
    int style;
    style = $urandom_range(3);
    set_idling(settings_used);
    load_setup(w, h, pick_kernel_row(style), pick_kernel_row(style), pick_kernel_row(style));
    for (int f = 0; f < nframes; f++) run_frame(f == 0);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    load_setup(11'd3, 11'd2, {16'h0040, 16'hFF00, 16'h0020},
               {16'hFFC0, 16'h0200, 16'h0080}, {16'h0010, 16'hFF80, 16'h0030});
    push_req(1'b0, 8'd0);
    push_req(1'b0, 8'd255);
    push_req(1'b1, 8'd255);
    push_req(1'b0, 8'd17);
    push_req(1'b0, 8'd255);
    push_req(1'b0, 8'd0);
    push_req(1'b0, 8'd128);
    push_req(1'b1, 8'd0);
    push_req(1'b0, 8'd255);
    push_req(1'b1, 8'd77);
    push_req(1'b0, 8'd1);
    push_req(1'b1, 8'd9);

    load_setup(11'd1, 11'd1, '0, {16'h0000, 16'h7FFF, 16'h0000}, '0);
    push_req(1'b0, 8'd255);
    push_req(1'b1, 8'd0);
    push_req(1'b1, 8'd0);

    load_setup(11'd0, 11'd0, {3{16'h7FFF}}, {16'h7FFF, 16'h8000, 16'h7FFF}, {3{16'h7FFF}});
    push_req(1'b0, 8'd200);
    push_req(1'b1, 8'd0);
    push_req(1'b0, 8'd255);

    while (items_sent < 400) begin
      if ($urandom_range(7) == 0)
        run_setting(SIZE_W'($urandom_range(13, 48)), SIZE_W'($urandom_range(1, 4)), 1);
      else
        run_setting(SIZE_W'($urandom_range(1, 12)), SIZE_W'($urandom_range(1, 8)),
                    $urandom_range(1, 3));
    end

    run_setting(11'd1, 11'd2047, 1);
    run_setting(11'd0, 11'd5, 2);
    run_setting(11'd7, 11'd0, 2);

    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d requests over %0d settings, %0d result pixels in %0d frames",
             items_sent, settings_used, results_seen, frames_seen);
    $display("sizes from 1x1 up to 48 wide and 1024 tall, with idle and stall mixes");
    if (errors == 0 && pending == 0)
      $display("tb_image_convolution_3x3 passed");
    else
      $display("tb_image_convolution_3x3 failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/ic3_pkg.sv
rtl/core/ic3_ram.sv
rtl/core/ic3_cell.sv
rtl/core/ic3_outq.sv
rtl/core/image_convolution_3x3.sv
tb/image_convolution_3x3_checker.sv
tb/tb_image_convolution_3x3.sv
